/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl modules
// both expect i_clk and i_rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_CLK(lbl, !(cond), msg)

`endif

/* hw/rtl/vvps_pkg.sv */
package vvps_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int REG_W     = 31;
    localparam int KE_W      = 63;
    localparam int LANES     = 3;
    localparam int CMD_W     = 2;
    localparam int IDX_W     = 3;
    localparam int TUSER_W   = 4;

    // lane multiplier: 33 x 32 signed
    localparam int PROD_W = 2 * DATA_W + 1;
    localparam int SAT_W  = PROD_W + 1;
    localparam int SQ_W   = 2 * DATA_W - 1;

    // energy path
    localparam int SUM_W   = 2 * DATA_W;
    localparam int S_W     = SUM_W - FRAC_BITS;
    localparam int S_LO_W  = DATA_W;
    localparam int S_HI_W  = S_W - S_LO_W;
    localparam int PP_LO_W = S_LO_W + REG_W;
    localparam int PP_HI_W = S_HI_W + REG_W;
    localparam int PP_W    = S_W + REG_W;

    localparam int IN_DATA_W  = 3 * LANES * DATA_W;
    localparam int OUT_RAW_W  = 2 * LANES * DATA_W + KE_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_RAW_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_HALF  = 2'd0,
        CMD_FULL  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    localparam logic [IDX_W-1:0] REG_STEP  = 3'd0;
    localparam logic [IDX_W-1:0] REG_PINV  = 3'd1;
    localparam logic [IDX_W-1:0] REG_SINV  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SMASS = 3'd3;
    localparam logic [IDX_W-1:0] REG_BOX   = 3'd4;
    localparam logic [IDX_W-1:0] REG_RECIP = 3'd5;

    localparam logic [REG_W-1:0] RST_STEP = REG_W'(66);
    localparam logic [REG_W-1:0] RST_ONE  = REG_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        LOP_ECHO,
        LOP_HALF,
        LOP_FULL
    } t_lane_op;

    typedef struct packed {
        t_lane_op         op;
        logic             wrap_en;
        logic             square_en;
        logic [REG_W-1:0] inv;
    } t_lane_ctl;

    typedef struct packed {
        logic [REG_W-1:0] dt;
        logic [REG_W-1:0] recip;
        logic [REG_W-1:0] box;
    } t_lane_cfg;

    // clamp a wide signed value into the data range
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SAT_W-1:0] x);
        if ((&x[SAT_W-1:DATA_W-1]) || !(|x[SAT_W-1:DATA_W-1])) begin
            return x[DATA_W-1:0];
        end
        return x[SAT_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

endpackage

/* hw/rtl/vvps_lane.sv */
`include "assert_macros.svh"

module vvps_lane
    import vvps_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  t_lane_ctl                i_ctl,
    input  t_lane_cfg                i_cfg,
    input  logic signed [DATA_W-1:0] i_pos,
    input  logic signed [DATA_W-1:0] i_vel,
    input  logic signed [DATA_W-1:0] i_force,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_pos,
    output logic signed [DATA_W-1:0] o_vel,
    output logic [SQ_W-1:0]          o_square
);

    localparam int OPA_W = DATA_W + 1;
    localparam int RND_W = 2 * DATA_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KICK_A,
        ST_KICK_B,
        ST_KICK_C,
        ST_DRIFT_A,
        ST_DRIFT_B,
        ST_WRAP_A,
        ST_WRAP_B,
        ST_WRAP_C,
        ST_WRAP_D,
        ST_SQUARE,
        ST_DONE
    } t_state;

    t_state                    r_state;
    t_lane_ctl                 r_ctl;
    logic signed [DATA_W-1:0]  r_pos;
    logic signed [DATA_W-1:0]  r_vel;
    logic signed [DATA_W-1:0]  r_force;
    logic signed [PROD_W-1:0]  r_prod;
    logic [REG_W-1:0]          r_n;

    logic signed [OPA_W-1:0]   w_ma;
    logic signed [DATA_W-1:0]  w_mb;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [DATA_W-1:0]  w_accel;
    logic [DATA_W-1:0]         w_mag;
    logic [RND_W-1:0]          w_round;
    logic [RND_W-1:0]          w_nq;

    assign w_accel = sat_data(SAT_W'(r_prod >>> FRAC_BITS));
    assign w_mag   = r_pos[DATA_W-1] ? (~r_pos + 1'b1) : r_pos;
    // image count, rounded half away from zero on the magnitude
    assign w_round = RND_W'(r_prod) + (RND_W'(1) << (2 * FRAC_BITS - 1));
    assign w_nq    = w_round >> (2 * FRAC_BITS);

    always_comb begin
        unique case (r_state)
            ST_KICK_A: begin
                w_ma = OPA_W'(r_force);
                w_mb = signed'({1'b0, r_ctl.inv});
            end
            ST_KICK_B: begin
                w_ma = OPA_W'(w_accel);
                w_mb = signed'({1'b0, i_cfg.dt});
            end
            ST_DRIFT_A: begin
                w_ma = OPA_W'(r_vel);
                w_mb = signed'({1'b0, i_cfg.dt});
            end
            ST_SQUARE: begin
                w_ma = OPA_W'(r_vel);
                w_mb = r_vel;
            end
            ST_WRAP_A: begin
                w_ma = signed'({1'b0, w_mag});
                w_mb = signed'({1'b0, i_cfg.recip});
            end
            ST_WRAP_C: begin
                w_ma = signed'({2'b00, r_n});
                w_mb = signed'({1'b0, i_cfg.box});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_ma) * PROD_W'(w_mb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_ctl   <= i_ctl;
                        r_pos   <= i_pos;
                        r_vel   <= i_vel;
                        r_force <= i_force;
                        r_state <= (i_ctl.op == LOP_ECHO) ? ST_DONE : ST_KICK_A;
                    end
                end
                ST_KICK_A: begin
                    r_prod  <= w_prod;
                    r_state <= ST_KICK_B;
                end
                ST_KICK_B: begin
                    r_prod  <= w_prod;
                    r_state <= ST_KICK_C;
                end
                ST_KICK_C: begin
                    r_vel <= sat_data(SAT_W'(r_vel) + SAT_W'(r_prod >>> (FRAC_BITS + 1)));
                    if (r_ctl.op == LOP_HALF) begin
                        r_state <= ST_DRIFT_A;
                    end else if (r_ctl.square_en) begin
                        r_state <= ST_SQUARE;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DRIFT_A: begin
                    r_prod  <= w_prod;
                    r_state <= ST_DRIFT_B;
                end
                ST_DRIFT_B: begin
                    r_pos   <= sat_data(SAT_W'(r_pos) + SAT_W'(r_prod >>> FRAC_BITS));
                    r_state <= r_ctl.wrap_en ? ST_WRAP_A : ST_DONE;
                end
                ST_WRAP_A: begin
                    r_prod  <= w_prod;
                    r_state <= ST_WRAP_B;
                end
                ST_WRAP_B: begin
                    r_n     <= (|w_nq[RND_W-1:REG_W]) ? '1 : w_nq[REG_W-1:0];
                    r_state <= ST_WRAP_C;
                end
                ST_WRAP_C: begin
                    r_prod  <= w_prod;
                    r_state <= ST_WRAP_D;
                end
                ST_WRAP_D: begin
                    // move toward zero by n box lengths
                    r_pos <= r_pos[DATA_W-1] ? sat_data(SAT_W'(r_pos) + SAT_W'(r_prod))
                                             : sat_data(SAT_W'(r_pos) - SAT_W'(r_prod));
                    r_state <= ST_DONE;
                end
                ST_SQUARE: begin
                    r_prod  <= w_prod;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done   = (r_state == ST_DONE);
    assign o_pos    = r_pos;
    assign o_vel    = r_vel;
    assign o_square = r_prod[SQ_W-1:0];

    `ASSERT_NEVER(a_start_busy, i_start && (r_state != ST_IDLE), "lane started while busy")

endmodule

/* hw/rtl/vvps_energy.sv */
`include "assert_macros.svh"

module vvps_energy
    import vvps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_clear,
    input  logic [SQ_W-1:0]  i_square [LANES],
    input  logic [REG_W-1:0] i_mass,
    output logic             o_done,
    output logic [KE_W-1:0]  o_sum
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SCALE,
        ST_ACCUM,
        ST_DONE
    } t_state;

    t_state               r_state;
    logic [S_W-1:0]       r_s;
    logic [PP_LO_W-1:0]   r_pp_lo;
    logic [PP_HI_W-1:0]   r_pp_hi;
    logic [KE_W-1:0]      r_e;
    logic [KE_W-1:0]      r_sum;

    logic [SUM_W-1:0]     w_sq_sum;
    logic [PP_W-1:0]      w_pp;
    logic [PP_W-1:0]      w_q;
    logic [KE_W:0]        w_acc;

    always_comb begin
        w_sq_sum = '0;
        for (int i = 0; i < LANES; i++) begin
            w_sq_sum = w_sq_sum + SUM_W'(i_square[i]);
        end
    end

    // 31-bit mass times the split sum, two partial products
    assign w_pp  = (PP_W'(r_pp_hi) << S_LO_W) + PP_W'(r_pp_lo);
    assign w_q   = w_pp >> (FRAC_BITS + 1);
    assign w_acc = {1'b0, r_sum} + {1'b0, r_e};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sum   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_clear) begin
                        r_sum <= '0;
                    end
                    if (i_start) begin
                        r_s     <= w_sq_sum[SUM_W-1:FRAC_BITS];
                        r_state <= ST_MUL_LO;
                    end
                end
                ST_MUL_LO: begin
                    r_pp_lo <= PP_LO_W'(r_s[S_LO_W-1:0]) * PP_LO_W'(i_mass);
                    r_state <= ST_MUL_HI;
                end
                ST_MUL_HI: begin
                    r_pp_hi <= PP_HI_W'(r_s[S_W-1:S_LO_W]) * PP_HI_W'(i_mass);
                    r_state <= ST_SCALE;
                end
                ST_SCALE: begin
                    r_e     <= (|w_q[PP_W-1:KE_W]) ? '1 : w_q[KE_W-1:0];
                    r_state <= ST_ACCUM;
                end
                ST_ACCUM: begin
                    r_sum   <= w_acc[KE_W] ? '1 : w_acc[KE_W-1:0];
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == ST_DONE);
    assign o_sum  = r_sum;

    `ASSERT_CLK(a_sum_monotone, !i_clear |=> (r_sum >= $past(r_sum)), "energy sum dropped")

endmodule

/* hw/rtl/velocity_verlet_particle_step_unit.sv */
// every input gives one result on o_m_tvalid: half step, half step with box wrap,
// full step, observed solvent full step, clear or no-op
// a new input is taken only while idle, from the cycle after the result is loaded,
// and loading waits while the output register holds a result not yet taken;
// each of the three lanes has a single multiplier; reset (i_rst_n low at a clock edge)
// empties the block, zeroes the energy sum and loads the register defaults
`include "assert_macros.svh"

module velocity_verlet_particle_step_unit
    import vvps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, force_x, force_y, force_z
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // cmd[1:0], is_solvent[2], observe[3]
    input  logic [TUSER_W-1:0]    i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    // kinetic_energy, one zero pad bit
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [IDX_W-1:0]      i_cfg_index,
    input  logic [REG_W-1:0]      i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LANES,
        ST_ENERGY,
        ST_OUTPUT
    } t_state;

    logic [REG_W-1:0] r_step;
    logic [REG_W-1:0] r_pinv;
    logic [REG_W-1:0] r_sinv;
    logic [REG_W-1:0] r_smass;
    logic [REG_W-1:0] r_box;
    logic [REG_W-1:0] r_recip;

    t_state                    r_state;
    logic                      r_energy;
    logic                      r_clear;
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_out_pos [LANES];
    logic signed [DATA_W-1:0]  r_out_vel [LANES];
    logic [KE_W-1:0]           r_out_ke;

    t_cmd                      w_cmd;
    logic                      w_solvent;
    logic                      w_observe;
    logic                      w_accept;
    logic                      w_load;
    t_lane_ctl                 w_ctl;
    t_lane_cfg                 w_cfg;
    logic [LANES-1:0]          w_lane_done;
    logic signed [DATA_W-1:0]  w_lane_pos [LANES];
    logic signed [DATA_W-1:0]  w_lane_vel [LANES];
    logic [SQ_W-1:0]           w_lane_sq  [LANES];
    logic                      w_e_start;
    logic                      w_e_clear;
    logic                      w_e_done;
    logic [KE_W-1:0]           w_ke;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= RST_STEP;
            r_pinv  <= RST_ONE;
            r_sinv  <= RST_ONE;
            r_smass <= RST_ONE;
            r_box   <= '0;
            r_recip <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_STEP:  r_step  <= i_cfg_data;
                REG_PINV:  r_pinv  <= i_cfg_data;
                REG_SINV:  r_sinv  <= i_cfg_data;
                REG_SMASS: r_smass <= i_cfg_data;
                REG_BOX:   r_box   <= i_cfg_data;
                REG_RECIP: r_recip <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cmd      = t_cmd'(i_s_tuser[1:0]);
    assign w_solvent  = i_s_tuser[2];
    assign w_observe  = i_s_tuser[3];
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        unique case (w_cmd) inside
            CMD_HALF:           w_ctl.op = LOP_HALF;
            CMD_FULL:           w_ctl.op = LOP_FULL;
            CMD_CLEAR, CMD_NOP: w_ctl.op = LOP_ECHO;
            default:            w_ctl.op = LOP_ECHO;
        endcase
        w_ctl.wrap_en   = w_solvent && (r_box != '0);
        w_ctl.square_en = (w_cmd == CMD_FULL) && w_solvent && w_observe;
        w_ctl.inv       = w_solvent ? r_sinv : r_pinv;
    end

    assign w_cfg.dt    = r_step;
    assign w_cfg.recip = r_recip;
    assign w_cfg.box   = r_box;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        vvps_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_start  (w_accept),
            .i_ctl    (w_ctl),
            .i_cfg    (w_cfg),
            .i_pos    (signed'(i_s_tdata[g*DATA_W +: DATA_W])),
            .i_vel    (signed'(i_s_tdata[(LANES+g)*DATA_W +: DATA_W])),
            .i_force  (signed'(i_s_tdata[(2*LANES+g)*DATA_W +: DATA_W])),
            .o_done   (w_lane_done[g]),
            .o_pos    (w_lane_pos[g]),
            .o_vel    (w_lane_vel[g]),
            .o_square (w_lane_sq[g])
        );

        assign o_m_tdata[g*DATA_W +: DATA_W]         = r_out_pos[g];
        assign o_m_tdata[(LANES+g)*DATA_W +: DATA_W] = r_out_vel[g];
    end

    assign o_m_tdata[2*LANES*DATA_W +: KE_W]        = r_out_ke;
    assign o_m_tdata[OUT_DATA_W-1 -: OUT_PAD_W]      = '0;

    // lanes run in lockstep, lane 0 speaks for all
    assign w_e_start = (r_state == ST_LANES) && w_lane_done[0] && r_energy;
    assign w_e_clear = (r_state == ST_LANES) && w_lane_done[0] && r_clear;

    // output register free or emptied by this transfer
    assign w_load = (r_state == ST_OUTPUT) && (!r_out_valid || i_m_tready);

    vvps_energy u_energy (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_e_start),
        .i_clear  (w_e_clear),
        .i_square (w_lane_sq),
        .i_mass   (r_smass),
        .o_done   (w_e_done),
        .o_sum    (w_ke)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_energy    <= 1'b0;
            r_clear     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_energy <= w_ctl.square_en;
                        r_clear  <= (w_cmd == CMD_CLEAR);
                        r_state  <= ST_LANES;
                    end
                end
                ST_LANES: begin
                    if (w_lane_done[0]) begin
                        r_state <= r_energy ? ST_ENERGY : ST_OUTPUT;
                    end
                end
                ST_ENERGY: begin
                    if (w_e_done) begin
                        r_state <= ST_OUTPUT;
                    end
                end
                ST_OUTPUT: begin
                    if (w_load) begin
                        r_out_pos   <= w_lane_pos;
                        r_out_vel   <= w_lane_vel;
                        r_out_ke    <= w_ke;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;

    `ASSERT_CLK(a_lane_sync, (&w_lane_done) || !(|w_lane_done), "lanes out of step")
    `ASSERT_CLK(a_energy_done_state, w_e_done |-> (r_state == ST_ENERGY), "stray energy done")
    `ASSERT_CLK(a_clear_zero, (r_state == ST_OUTPUT && r_clear) |-> (w_ke == '0), "sum not cleared")

endmodule
